[design/eer_pkg.sv]
// Shared constants, state type and control structs for the electron event decoder.
package eer_pkg;

   localparam int WORD_BITS = 64;
   localparam int RUN_BITS  = 7;
   localparam int SUB_BITS  = 4;
   localparam int CODE_BITS = RUN_BITS + SUB_BITS;
   localparam int POS_BITS  = 24;
   localparam int LEFT_BITS = CODE_BITS - 1;
   localparam int LCNT_BITS = 4;
   localparam int BUF_BITS  = WORD_BITS + LEFT_BITS + 1;
   localparam int CNT_BITS  = 7;
   localparam int CODES_MAX = 6;
   localparam int RSP_BITS  = 32;

   localparam logic [RUN_BITS-1:0] RUN_FULL = {RUN_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] POS_TOP  = {POS_BITS{1'b1}};

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DECODE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic has_code;
      logic last_code;
      logic emits;
      logic out_free;
   } status_type;

endpackage

[design/eer_ctrl.sv]
// Controller: word intake and per-code stepping of the decoder.
module eer_ctrl
   import eer_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.has_code) begin
               state_in = ST_IDLE;
            end else if (cmd.step && status.last_code) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DECODE: begin
            // a code that yields an electron waits for a free output register
            cmd.step = status.has_code && (!status.emits || status.out_free);
         end
         default: ;
      endcase
   end

endmodule

[design/eer_datapath.sv]
// Datapath: bit buffer, code split, position counter and result register.
module eer_datapath
   import eer_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [WORD_BITS-1:0] packed_word,
   input  logic                 frame_start,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_BITS-1:0]  rsp_tdata,
   output logic                 rsp_tlast
);

   logic [BUF_BITS-1:0]  buf_ff,   buf_in;
   logic [CNT_BITS-1:0]  bits_ff,  bits_in;
   logic [POS_BITS-1:0]  pos_ff,   pos_in;
   logic [LEFT_BITS-1:0] left_ff,  left_in;
   logic [LCNT_BITS-1:0] lcnt_ff,  lcnt_in;
   logic                 valid_ff, valid_in;
   logic [POS_BITS-1:0]  opos_ff,  opos_in;
   logic [SUB_BITS-1:0]  osub_ff,  osub_in;
   logic                 olast_ff, olast_in;

   logic [RUN_BITS-1:0]  run;
   logic [SUB_BITS-1:0]  sub;
   logic [POS_BITS:0]    sum_run;
   logic [POS_BITS-1:0]  pos_run;
   logic [POS_BITS:0]    sum_one;
   logic [POS_BITS-1:0]  pos_one;
   logic                 emits;
   logic                 later_emit;
   logic [LCNT_BITS-1:0] load_cnt;
   logic [LEFT_BITS-1:0] load_left;
   logic [BUF_BITS-1:0]  load_buf;

   assign run   = buf_ff[RUN_BITS-1:0];
   assign sub   = buf_ff[CODE_BITS-1:RUN_BITS];
   assign emits = (run != RUN_FULL);

   // saturating position updates: add run, then step past the electron
   assign sum_run = {1'b0, pos_ff} + {{(POS_BITS+1-RUN_BITS){1'b0}}, run};
   assign pos_run = sum_run[POS_BITS] ? POS_TOP : sum_run[POS_BITS-1:0];
   assign sum_one = {1'b0, pos_run} + {{POS_BITS{1'b0}}, 1'b1};
   assign pos_one = sum_one[POS_BITS] ? POS_TOP : sum_one[POS_BITS-1:0];

   // any electron among the whole codes still queued behind this one
   always_comb begin
      later_emit = 1'b0;
      for (int k = 1; k < CODES_MAX; k++) begin
         if ((bits_ff >= CNT_BITS'(CODE_BITS * (k + 1))) &&
             (buf_ff[k*CODE_BITS +: RUN_BITS] != RUN_FULL)) begin
            later_emit = 1'b1;
         end
      end
   end

   // new word lands above the leftover bits
   assign load_cnt  = frame_start ? '0 : lcnt_ff;
   assign load_left = frame_start ? '0 : left_ff;
   assign load_buf  = ({{(BUF_BITS-WORD_BITS){1'b0}}, packed_word} << load_cnt)
                    | {{(BUF_BITS-LEFT_BITS){1'b0}}, load_left};

   always_comb begin
      buf_in   = buf_ff;
      bits_in  = bits_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      lcnt_in  = lcnt_ff;
      opos_in  = opos_ff;
      osub_in  = osub_ff;
      olast_in = olast_ff;
      valid_in = valid_ff && !rsp_tready;
      if (cmd.load) begin
         buf_in  = load_buf;
         bits_in = CNT_BITS'(WORD_BITS) + {{(CNT_BITS-LCNT_BITS){1'b0}}, load_cnt};
         if (frame_start) begin
            pos_in = '0;
         end
      end else if (cmd.step) begin
         buf_in  = buf_ff >> CODE_BITS;
         bits_in = bits_ff - CNT_BITS'(CODE_BITS);
         pos_in  = emits ? pos_one : pos_run;
         if (status.last_code) begin
            left_in = buf_ff[CODE_BITS +: LEFT_BITS];
            lcnt_in = LCNT_BITS'(bits_ff - CNT_BITS'(CODE_BITS));
         end
         if (emits) begin
            valid_in = 1'b1;
            opos_in  = pos_run;
            osub_in  = sub;
            olast_in = !later_emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         pos_ff   <= '0;
         left_ff  <= '0;
         lcnt_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
         lcnt_ff  <= lcnt_in;
         valid_ff <= valid_in;
      end
      buf_ff   <= buf_in;
      opos_ff  <= opos_in;
      osub_ff  <= osub_in;
      olast_ff <= olast_in;
   end

   assign status.has_code  = (bits_ff >= CNT_BITS'(CODE_BITS));
   assign status.last_code = (bits_ff < CNT_BITS'(2 * CODE_BITS));
   assign status.emits     = emits;
   assign status.out_free  = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_BITS-POS_BITS-SUB_BITS){1'b0}}, osub_ff, opos_ff};
   assign rsp_tlast  = olast_ff;

endmodule

[design/eer_event_decoder_top.sv]
// Top level of the electron event decoder: controller, datapath and checks.
//
// Input stream (req_): each word is 64 bits of packed 11-bit event codes,
// LSB first; req_tuser[0] marks the first word of a frame and clears the
// pixel position and any leftover bits before the word is decoded.
// Codes straddle word boundaries; up to 10 tail bits carry to the next word.
// Output stream (rsp_): one word per electron with its pixel position and
// subpixel bits; rsp_tlast flags the last electron of each input word.
// Timing: a word is taken in the idle state, then its 5 or 6 codes are decoded
// one per cycle while no code waits on the output register. The earliest
// result is valid once the word is in the bit buffer and its first code, if it
// yields an electron, is stepped into the output register. req_tready is high only between words.
// Stalls: results go through a single output register; while it is full and
// rsp_tready is low, a code that yields an electron waits, while a code that
// only moves the position still proceeds.
// Reset clears the position, leftover bits and the output register; the
// block is ready for a word in the first cycle after reset drops.
module eer_event_decoder_top
   import eer_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [WORD_BITS-1:0] req_tdata,   // packed_word
   input  logic [0:0]           req_tuser,   // frame_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_BITS-1:0]  rsp_tdata,   // pixel_position[23:0], subpixel_bits[27:24]
   output logic                 rsp_tlast    // last_of_word
);

   cmd_type    cmd;
   status_type status;

   eer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   eer_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .packed_word (req_tdata),
      .frame_start (req_tuser[0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // busy right after taking a word
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("decoder ready again directly after a word");

   // a freshly loaded word always holds a whole code
   a_code_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> status.has_code)
      else $error("no whole code after word load");

   // an electron never overwrites a pending result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.emits |-> status.out_free)
      else $error("result register overwritten");
`endif

endmodule
